/* rtl/tag_presence_debouncer_defines.svh */
// Assertion macros for the tag presence debouncer.
`ifndef TAG_PRESENCE_DEBOUNCER_DEFINES_SVH
`define TAG_PRESENCE_DEBOUNCER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TPD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tpd: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tpd: next-cycle check failed");

`endif

/* rtl/tpd_pkg.sv */
// Shared constants, types and helpers for the tag presence debouncer.
package tpd_pkg;

   localparam int UID_BYTES  = 7;
   localparam int COUNT_BITS = 8;
   localparam int UID_W      = 56;
   localparam int LEN_W      = 3;
   localparam int OUTCOME_W  = 2;
   localparam int THR_W      = 8;
   localparam int CMP_W      = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;
   localparam int FIELD_BYTES = UID_W / 8;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DETECT_THR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REMOVE_THR = 2'd2;

   localparam logic [THR_W-1:0] DETECT_THR_RESET = 8'd2;
   localparam logic [THR_W-1:0] REMOVE_THR_RESET = 8'd3;

   localparam logic [OUTCOME_W-1:0] OUTCOME_READ = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_MISS = 2'd1;

   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   typedef struct packed {
      logic [UID_W-1:0]      uid;
      logic [LEN_W-1:0]      uid_len;
      logic [COUNT_BITS-1:0] detect_count;
      logic [COUNT_BITS-1:0] miss_count;
      logic                  tag_present;
   } state_type;

   typedef struct packed {
      logic             detected;
      logic [UID_W-1:0] uid;
      logic [LEN_W-1:0] uid_len;
   } event_type;

   // Keep only the bytes below len.
   function automatic logic [UID_W-1:0] bytes_mask(input logic [LEN_W-1:0] len);
      logic [UID_W-1:0] mask;
      mask = '0;
      for (int b = 0; b < FIELD_BYTES; b++) begin
         if (b < int'(len)) begin
            mask[b*8 +: 8] = 8'hFF;
         end
      end
      return mask;
   endfunction

endpackage

/* rtl/tpd_req_if.sv */
// Poll outcome channel.
interface tpd_req_if;
   logic                          valid;
   logic                          ready;
   logic [tpd_pkg::OUTCOME_W-1:0] poll_outcome;
   logic [tpd_pkg::UID_W-1:0]     tag_uid;
   logic [tpd_pkg::LEN_W-1:0]     tag_uid_len;

   modport source (output valid, output poll_outcome, output tag_uid,
                   output tag_uid_len, input ready);
   modport sink   (input valid, input poll_outcome, input tag_uid,
                   input tag_uid_len, output ready);
endinterface

// Presence event channel.
interface tpd_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      event_detected;
   logic [tpd_pkg::UID_W-1:0] event_uid;
   logic [tpd_pkg::LEN_W-1:0] event_uid_len;

   modport source (output valid, output event_detected, output event_uid,
                   output event_uid_len, input ready);
   modport sink   (input valid, input event_detected, input event_uid,
                   input event_uid_len, output ready);
endinterface

/* rtl/tpd_step.sv */
// Next-state and event logic for one poll outcome.
module tpd_step (
   input  logic                          enable,
   input  logic [tpd_pkg::THR_W-1:0]     detect_threshold,
   input  logic [tpd_pkg::THR_W-1:0]     remove_threshold,
   input  logic [tpd_pkg::OUTCOME_W-1:0] poll_outcome,
   input  logic [tpd_pkg::UID_W-1:0]     tag_uid,
   input  logic [tpd_pkg::LEN_W-1:0]     tag_uid_len,
   input  tpd_pkg::state_type            state_cur,
   output tpd_pkg::state_type            state_nxt,
   output logic                          emit,
   output tpd_pkg::event_type            evt
);
   import tpd_pkg::*;

   logic [LEN_W-1:0]      len;
   logic [UID_W-1:0]      mask;
   logic [UID_W-1:0]      uid;
   logic                  same;
   logic [COUNT_BITS-1:0] det_cnt;
   logic [COUNT_BITS-1:0] miss_cnt;

   always_comb begin
      // Clamp length to the UID size.
      len = tag_uid_len;
      if (int'(tag_uid_len) > UID_BYTES) begin
         len = LEN_W'(UID_BYTES);
      end
      mask = bytes_mask(len);
      uid  = tag_uid & mask;
      same = (len == state_cur.uid_len) && (len != '0) &&
             ((state_cur.uid & mask) == uid);
      det_cnt  = same ? ((state_cur.detect_count != CNT_MAX) ?
                         state_cur.detect_count + 1'b1 : state_cur.detect_count)
                      : COUNT_BITS'(1);
      miss_cnt = (state_cur.miss_count != CNT_MAX) ?
                 state_cur.miss_count + 1'b1 : state_cur.miss_count;

      state_nxt = state_cur;
      emit      = 1'b0;
      evt       = '0;

      if (enable) begin
         if (poll_outcome == OUTCOME_READ) begin
            state_nxt.miss_count   = '0;
            state_nxt.detect_count = det_cnt;
            if (!same) begin
               state_nxt.uid     = uid;
               state_nxt.uid_len = len;
            end
            if (!state_cur.tag_present &&
                (CMP_W'(det_cnt) >= CMP_W'(detect_threshold))) begin
               state_nxt.tag_present = 1'b1;
               emit         = 1'b1;
               evt.detected = 1'b1;
               evt.uid      = uid;
               evt.uid_len  = len;
            end
         end else if (poll_outcome == OUTCOME_MISS) begin
            state_nxt.detect_count = '0;
            if (state_cur.tag_present) begin
               state_nxt.miss_count = miss_cnt;
               if (CMP_W'(miss_cnt) >= CMP_W'(remove_threshold)) begin
                  state_nxt.tag_present = 1'b0;
                  state_nxt.miss_count  = '0;
                  state_nxt.uid_len     = '0;
                  emit = 1'b1;
               end
            end else begin
               state_nxt.miss_count = '0;
            end
         end
      end
   end

endmodule

/* rtl/tag_presence_debouncer.sv */
// Top level of the tag presence debouncer: registers, handshakes and CSRs.
//
//   channel   dir  handshake            payload
//   req_bus   in   valid/ready          poll_outcome, tag_uid, tag_uid_len
//   rsp_bus   out  valid/ready          event_detected, event_uid, event_uid_len
//   csr_*     in   csr_we (no ready)    csr_index, csr_wdata
//
// An item passes from acceptance through the input register and the step
// logic into the output register. One item is accepted per cycle unless a
// stalled event holds the input register; the state update commits as the
// item leaves it, so back-to-back items see each other's effect.
// A stalled result only blocks an item that itself raises an event; items
// with no event keep flowing past it.
// Active-high sync reset clears valids, counters, presence; CSRs get defaults.
`include "tag_presence_debouncer_defines.svh"

module tag_presence_debouncer (
   input  logic                           clock,
   input  logic                           reset,
   tpd_req_if.sink                        req_bus,
   tpd_rsp_if.source                      rsp_bus,
   input  logic                           csr_we,
   input  logic [tpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tpd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tpd_pkg::*;

   // Configuration registers.
   logic             enable_ff;
   logic [THR_W-1:0] detect_thr_ff;
   logic [THR_W-1:0] remove_thr_ff;

   // Input register.
   logic                 s1_valid_ff;
   logic [OUTCOME_W-1:0] s1_outcome_ff;
   logic [UID_W-1:0]     s1_uid_ff;
   logic [LEN_W-1:0]     s1_len_ff;

   // Tracking state.
   state_type state_ff;
   state_type state_in;

   // Output register.
   logic      rsp_valid_ff;
   event_type rsp_event_ff;

   logic      emit;
   event_type evt;
   logic      out_free;
   logic      s1_advance;
   logic      req_take;

   tpd_step u_step (
      .enable           (enable_ff),
      .detect_threshold (detect_thr_ff),
      .remove_threshold (remove_thr_ff),
      .poll_outcome     (s1_outcome_ff),
      .tag_uid          (s1_uid_ff),
      .tag_uid_len      (s1_len_ff),
      .state_cur        (state_ff),
      .state_nxt        (state_in),
      .emit             (emit),
      .evt              (evt)
   );

   // Output register frees up when empty or when its item leaves now.
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   // Advance the input register unless its event has nowhere to go.
   assign s1_advance = s1_valid_ff && (!emit || out_free);
   assign req_bus.ready = !s1_valid_ff || s1_advance;
   assign req_take   = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.event_detected = rsp_event_ff.detected;
   assign rsp_bus.event_uid      = rsp_event_ff.uid;
   assign rsp_bus.event_uid_len  = rsp_event_ff.uid_len;

   // CSR writes; unknown indexes drop silently.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         detect_thr_ff <= DETECT_THR_RESET;
         remove_thr_ff <= REMOVE_THR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLE:     enable_ff     <= csr_wdata[0];
            CSR_DETECT_THR: detect_thr_ff <= csr_wdata[THR_W-1:0];
            CSR_REMOVE_THR: remove_thr_ff <= csr_wdata[THR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Input register: load on accept, drop once processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_outcome_ff <= req_bus.poll_outcome;
         s1_uid_ff     <= req_bus.tag_uid;
         s1_len_ff     <= req_bus.tag_uid_len;
      end
   end

   // Commit the state only when the item is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (s1_advance) begin
         state_ff <= state_in;
      end
   end

   // Output register: hold until taken, load a new event when free.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && emit) begin
         rsp_event_ff <= evt;
      end
   end

   // A removal event carries no UID and no length.
   `TPD_ASSERT_SAME(a_removed_is_zero, clock, reset,
      rsp_valid_ff && !rsp_event_ff.detected,
      (rsp_event_ff.uid == '0) && (rsp_event_ff.uid_len == '0))
   // A detected event leaves the tag marked present.
   `TPD_ASSERT_NEXT(a_detect_sets_present, clock, reset,
      s1_advance && emit && evt.detected, state_ff.tag_present)
   // Misses are only counted while a tag is present.
   `TPD_ASSERT_SAME(a_miss_needs_tag, clock, reset,
      !state_ff.tag_present, state_ff.miss_count == '0)

endmodule
